/* rtl/sspq_pkg.sv */
// Shared types and codes for the stable sorted priority queue.
package sspq_pkg;

    localparam int PRIO_W    = 8;
    localparam int MINUTES_W = 10;
    localparam int PRICE_W   = 16;
    localparam int LEVEL_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [PRICE_W-1:0]   price;
        logic [MINUTES_W-1:0] minutes;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic execute;
    } dp_cmd_t;

endpackage

/* rtl/sspq_ctrl.sv */
// Controller state machine for the stable sorted priority queue.
module sspq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sspq_pkg::dp_cmd_t dp_cmd
);
    import sspq_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        in_ready         = 1'b0;
        dp_cmd.latch_in  = 1'b0;
        dp_cmd.execute   = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.latch_in = 1'b1;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result register must be free or draining this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.execute = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/sspq_datapath.sv */
// Compare-and-shift cell row, entry count and result register of the queue.
module sspq_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sspq_pkg::dp_cmd_t                 dp_cmd,
    input  logic                              in_cmd,
    input  sspq_pkg::entry_t                  in_entry,
    output logic [sspq_pkg::STATUS_W-1:0]     out_status,
    output sspq_pkg::entry_t                  out_entry,
    output logic [sspq_pkg::OCC_W-1:0]        out_occ
);
    import sspq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic             cmd_reg;
    entry_t           new_reg;
    entry_t           cell_reg [QUEUE_DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [QUEUE_DEPTH-1:0] le;
    logic             full;
    logic             empty;
    logic             insert_en;
    logic             remove_en;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t           res_reg;
    entry_t           res_next;
    logic [OCC_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch_in)
        begin
            cmd_reg <= in_cmd;
            new_reg <= in_entry;
        end
    end

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign insert_en = dp_cmd.execute && (cmd_reg == CMD_INSERT) && !full;
    assign remove_en = dp_cmd.execute && (cmd_reg == CMD_REMOVE) && !empty;

    // Entries at or below the new priority form a prefix of the sorted row.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(gi);

            assign le[gi] = (IDX < count_reg) && (cell_reg[gi].prio <= new_reg.prio);

            always_ff @(posedge clk)
            begin
                if (insert_en && !le[gi])
                begin
                    if (gi == 0)
                    begin
                        cell_reg[gi] <= new_reg;
                    end
                    else if (le[(gi > 0) ? gi - 1 : 0])
                    begin
                        cell_reg[gi] <= new_reg;
                    end
                    else
                    begin
                        cell_reg[gi] <= cell_reg[(gi > 0) ? gi - 1 : 0];
                    end
                end
                else if (remove_en && (gi < QUEUE_DEPTH - 1))
                begin
                    cell_reg[gi] <= cell_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = STAT_INSERTED;
        res_next    = '0;
        if (cmd_reg == CMD_INSERT)
        begin
            if (full)
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STAT_EMPTY;
            end
            else
            begin
                status_next = STAT_REMOVED;
                res_next    = cell_reg[0];
                count_next  = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.execute)
        begin
            status_reg <= status_next;
            res_reg    <= res_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign out_status = status_reg;
    assign out_entry  = res_reg;
    assign out_occ    = occ_reg;

endmodule

/* rtl/stable_sorted_priority_queue.sv */
// Top level of the stable sorted priority queue: stream ports, controller and datapath.
// Steps: a transaction is captured into the input registers, then the parallel compare-and-shift
// update of the cell row writes the result register once that register is free or draining.
// No new transaction is accepted until the current one has executed.
// A finished result waits in the output register while the next transaction is accepted.
// Reset clears the controller and the entry count; cell contents are not reset.
module stable_sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // prio, minutes_early, price_paid, status_level
    input  logic [0:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_prio, out_minutes, out_price, out_level, occupancy
    output logic [1:0]  m_axis_tuser    // status
);
    import sspq_pkg::*;

    dp_cmd_t             dp_cmd;
    entry_t              in_entry;
    entry_t              out_entry;
    logic [STATUS_W-1:0] out_status;
    logic [OCC_W-1:0]    out_occ;

    // Input transaction fields, packed from the lowest bit up.
    assign in_entry.prio    = s_axis_tdata[7:0];
    assign in_entry.minutes = s_axis_tdata[17:8];
    assign in_entry.price   = s_axis_tdata[33:18];
    assign in_entry.level   = s_axis_tdata[36:34];

    // The controller sequences capture and execution; it also owns the result valid flag.
    sspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dp_cmd    (dp_cmd)
    );

    // The datapath holds the sorted cell row; an insert shifts the tail of the row
    // back by one behind every entry of equal or lower priority, a removal shifts it forward.
    sspq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .in_cmd     (s_axis_tuser[0]),
        .in_entry   (in_entry),
        .out_status (out_status),
        .out_entry  (out_entry),
        .out_occ    (out_occ)
    );

    assign m_axis_tdata = {4'd0, out_occ, out_entry.level, out_entry.price,
                           out_entry.minutes, out_entry.prio};
    assign m_axis_tuser = out_status;

endmodule
